// ----- rtl/core/assert_macros.svh -----
// assertion helpers used by prime_sieve_table
// clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: property failed");

`define ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(name, prop)

`define ASSERT_NEVER(name, cond)

`endif

`endif

// ----- rtl/core/pst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_pkg
// Types and constants shared by the prime sieve table front, queue and engine.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int unsigned LimW       = 16; // width of limits and query numbers
  localparam int unsigned NumW       = 17; // sieve counters, room for lim + p
  localparam int unsigned RootW      = 9;  // base prime, reaches at most 256
  localparam int unsigned QueueDepth = 4;  // power of two

  localparam logic ReqBuild = 1'b0;
  localparam logic ReqQuery = 1'b1;

  localparam logic [LimW-1:0] LimitReset = 16'd1023;

  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatRange    = 2'd1,
    StatNotBuilt = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    SvIdle,
    SvFill,
    SvCheck,
    SvProbe,
    SvMark,
    SvDone
  } sieve_state_e;

  typedef struct packed {
    logic            is_query;
    logic [LimW-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic            busy;
    logic            table_valid;
    logic [LimW-1:0] built_limit;
  } eng_status_t;

endpackage

// ----- rtl/core/pst_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_front
// Input stage: registers each request and decodes it into a command.
// ----------------------------------------------------------------------------
module pst_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      in_type_i,
  input  logic [pst_pkg::LimW-1:0]  in_value_i,
  output logic                      cmd_valid_o,
  input  logic                      cmd_ready_i,
  output pst_pkg::cmd_t             cmd_o
);

  logic          valid_q, valid_d;
  pst_pkg::cmd_t cmd_q, cmd_d;
  logic          take;

  assign in_ready_o  = !valid_q || cmd_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // build requests carry no number
  always_comb begin
    cmd_d.is_query = (in_type_i == pst_pkg::ReqQuery);
    cmd_d.value    = cmd_d.is_query ? in_value_i : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

// ----- rtl/core/pst_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_fifo
// Short command queue between the input stage and the sieve engine.
// ----------------------------------------------------------------------------
module pst_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  pst_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output pst_pkg::cmd_t pop_data_o
);

  localparam int unsigned PtrW = $clog2(pst_pkg::QueueDepth);

  pst_pkg::cmd_t   entry_q [pst_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != (PtrW+1)'(pst_pkg::QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/core/pst_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_engine
// Flag memory, sieve sequencer and query read pipeline with result register.
// ----------------------------------------------------------------------------
module pst_engine #(
  parameter int unsigned TABLE_DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_valid_i,
  output logic                     cmd_ready_o,
  input  pst_pkg::cmd_t            cmd_i,
  input  logic [pst_pkg::LimW-1:0] limit_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output logic                     res_is_prime_o,
  output pst_pkg::status_e         res_status_o,
  output pst_pkg::eng_status_t     status_o
);

  localparam int unsigned AW     = $clog2(TABLE_DEPTH);
  localparam int unsigned MaxNum = TABLE_DEPTH - 1;
  localparam int unsigned LimW   = pst_pkg::LimW;
  localparam int unsigned NumW   = pst_pkg::NumW;
  localparam int unsigned RootW  = pst_pkg::RootW;

  // flag memory, one bit per number
  logic          flags_q [TABLE_DEPTH];
  logic          rd_data_q;
  logic          rd_en, wr_en, wr_bit;
  logic [AW-1:0] rd_addr, wr_addr;

  pst_pkg::sieve_state_e state_q, state_d;
  logic [NumW-1:0]  num_q, num_d;    // fill index, then composite walker
  logic [RootW-1:0] p_q, p_d;
  logic [NumW-1:0]  psq_q, psq_d;    // p*p kept by running sum
  logic [LimW-1:0]  lim_q, lim_d;
  logic             tv_q, tv_d;
  logic [LimW-1:0]  bl_q, bl_d;

  logic             s1_valid_q, s1_valid_d;
  logic             s1_use_q, s1_use_d;
  pst_pkg::status_e s1_status_q, s1_status_d;

  logic             out_valid_q;
  logic             out_prime_q;
  pst_pkg::status_e out_status_q;

  logic            out_adv, s1_adv, s1_free, idle;
  logic            pop, q_pop, b_pop;
  logic [LimW-1:0] lim_sat;
  logic [NumW-1:0] lim_ext;
  logic [NumW-1:0] psq_next;

  assign idle    = (state_q == pst_pkg::SvIdle);
  assign out_adv = !out_valid_q || res_ready_i;
  assign s1_adv  = s1_valid_q && out_adv;
  assign s1_free = !s1_valid_q || out_adv;

  // a build waits for the read pipeline to drain since it reuses the read port
  assign cmd_ready_o = idle && (cmd_i.is_query ? s1_free : !s1_valid_q);
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign q_pop       = pop && cmd_i.is_query;
  assign b_pop       = pop && !cmd_i.is_query;

  assign lim_sat  = (32'(limit_i) > MaxNum) ? LimW'(MaxNum) : limit_i;
  assign lim_ext  = NumW'(lim_q);
  assign psq_next = psq_q + NumW'({p_q, 1'b1});

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pst_pkg::SvIdle: begin
        if (b_pop) begin
          state_d = pst_pkg::SvFill;
        end
      end
      pst_pkg::SvFill: begin
        if (num_q == lim_ext) begin
          state_d = pst_pkg::SvCheck;
        end
      end
      pst_pkg::SvCheck: begin
        state_d = (psq_q > lim_ext) ? pst_pkg::SvDone : pst_pkg::SvProbe;
      end
      pst_pkg::SvProbe: begin
        state_d = rd_data_q ? pst_pkg::SvMark : pst_pkg::SvCheck;
      end
      pst_pkg::SvMark: begin
        if (num_q > lim_ext) begin
          state_d = pst_pkg::SvCheck;
        end
      end
      pst_pkg::SvDone: begin
        state_d = pst_pkg::SvIdle;
      end
      default: begin
        state_d = pst_pkg::SvIdle;
      end
    endcase
  end

  // sequencer datapath and memory ports
  always_comb begin
    num_d   = num_q;
    p_d     = p_q;
    psq_d   = psq_q;
    lim_d   = lim_q;
    tv_d    = tv_q;
    bl_d    = bl_q;
    wr_en   = 1'b0;
    wr_bit  = 1'b0;
    wr_addr = AW'(num_q);
    rd_en   = q_pop;
    rd_addr = AW'(cmd_i.value);
    unique case (state_q)
      pst_pkg::SvIdle: begin
        if (b_pop) begin
          num_d = '0;
          lim_d = lim_sat;
        end
      end
      pst_pkg::SvFill: begin
        wr_en  = 1'b1;
        wr_bit = (num_q >= NumW'(2));
        num_d  = num_q + 1'b1;
        p_d    = RootW'(2);
        psq_d  = NumW'(4);
      end
      pst_pkg::SvCheck: begin
        rd_en   = 1'b1;
        rd_addr = AW'(p_q);
      end
      pst_pkg::SvProbe: begin
        if (rd_data_q) begin
          num_d = psq_q;
        end else begin
          p_d   = p_q + 1'b1;
          psq_d = psq_next;
        end
      end
      pst_pkg::SvMark: begin
        if (num_q > lim_ext) begin
          p_d   = p_q + 1'b1;
          psq_d = psq_next;
        end else begin
          wr_en = 1'b1;
          num_d = num_q + NumW'(p_q);
        end
      end
      pst_pkg::SvDone: begin
        tv_d = 1'b1;
        bl_d = lim_q;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // read pipeline stage: status is settled when the query leaves the queue
  always_comb begin
    s1_valid_d  = s1_valid_q;
    s1_use_d    = s1_use_q;
    s1_status_d = s1_status_q;
    if (q_pop) begin
      s1_valid_d = 1'b1;
      s1_use_d   = 1'b0;
      if (!tv_q) begin
        s1_status_d = pst_pkg::StatNotBuilt;
      end else if (cmd_i.value > bl_q) begin
        s1_status_d = pst_pkg::StatRange;
      end else begin
        s1_status_d = pst_pkg::StatOk;
        s1_use_d    = 1'b1;
      end
    end else if (state_q == pst_pkg::SvDone) begin
      s1_valid_d  = 1'b1;
      s1_use_d    = 1'b0;
      s1_status_d = pst_pkg::StatOk;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      flags_q[wr_addr] <= wr_bit;
    end
    if (rd_en) begin
      rd_data_q <= flags_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pst_pkg::SvIdle;
      tv_q        <= 1'b0;
      bl_q        <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      tv_q       <= tv_d;
      bl_q       <= bl_d;
      s1_valid_q <= s1_valid_d;
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    num_q       <= num_d;
    p_q         <= p_d;
    psq_q       <= psq_d;
    lim_q       <= lim_d;
    s1_use_q    <= s1_use_d;
    s1_status_q <= s1_status_d;
    if (s1_adv) begin
      out_prime_q  <= s1_use_q && rd_data_q;
      out_status_q <= s1_status_q;
    end
  end

  assign res_valid_o          = out_valid_q;
  assign res_is_prime_o       = out_prime_q;
  assign res_status_o         = out_status_q;
  assign status_o.busy        = !idle;
  assign status_o.table_valid = tv_q;
  assign status_o.built_limit = bl_q;

endmodule

// ----- rtl/core/prime_sieve_table.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// prime_sieve_table
// Primality table built by the sieve of Eratosthenes, with a query stream.
// ----------------------------------------------------------------------------
// Each request gives exactly one result. A query (tuser = 1) reads one bit of
// the flag memory; the block takes one query per cycle unless a build runs or
// the output stalls, and the result passes the input register, queue, read
// stage and result register. A build (tuser = 0) sieves 0..L with L =
// min(sieve_limit, TABLE_DEPTH-1); it waits for earlier queries to drain, fills
// the table, tests each p with p*p <= L, clears each multiple of each prime
// p <= sqrt(L) and moves on from it, ends with a last test and a done step,
// and its result then follows; the single flag memory write port paces it.
// Input is not taken once the input register and queue are full. The user must
// write the limit register only while no request is in flight; the block does not enforce it.
module prime_sieve_table #(
  parameter int unsigned TABLE_DEPTH = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,     // sieve_limit
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // query_value
  input  logic        s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // is_prime, status[1:0], zero pad
);

  localparam int unsigned MaxNum = TABLE_DEPTH - 1;

  logic [pst_pkg::LimW-1:0] limit_q;

  logic                 fe_valid, fe_ready;
  pst_pkg::cmd_t        fe_cmd;
  logic                 q_valid, q_ready;
  pst_pkg::cmd_t        q_cmd;
  logic                 res_prime;
  pst_pkg::status_e     res_status;
  pst_pkg::eng_status_t eng_st;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= pst_pkg::LimitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  pst_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_type_i   (s_axis_tuser),
    .in_value_i  (s_axis_tdata),
    .cmd_valid_o (fe_valid),
    .cmd_ready_i (fe_ready),
    .cmd_o       (fe_cmd)
  );

  pst_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_data_i  (fe_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_cmd)
  );

  pst_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (q_valid),
    .cmd_ready_o    (q_ready),
    .cmd_i          (q_cmd),
    .limit_i        (limit_q),
    .res_valid_o    (m_axis_tvalid),
    .res_ready_i    (m_axis_tready),
    .res_is_prime_o (res_prime),
    .res_status_o   (res_status),
    .status_o       (eng_st)
  );

  assign m_axis_tdata = {5'b00000, res_status, res_prime};

  // built limit never reaches past the table
  `ASSERT_NEVER(a_limit_in_table, 32'(eng_st.built_limit) > MaxNum)
  // a finished build always leaves a valid table
  `ASSERT_PROP(a_build_sets_valid, $fell(eng_st.busy) |-> eng_st.table_valid)
  // range errors only appear once a table exists
  `ASSERT_PROP(a_range_needs_table, (m_axis_tvalid && m_axis_tdata[2:1] == pst_pkg::StatRange) |-> eng_st.table_valid)
  // error results never claim a prime
  `ASSERT_PROP(a_error_not_prime, (m_axis_tvalid && m_axis_tdata[2:1] != pst_pkg::StatOk) |-> !m_axis_tdata[0])

endmodule
